FILE: hw/rtl/rqb_pkg.sv
// Shared types and constants of the retry queue with backoff.
package rqb_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned JIT_W      = 10;
  localparam int unsigned DELAY_W    = 20;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [DELAY_W-1:0] BASE_RESET = 20'd2000;
  localparam logic [DELAY_W-1:0] MAX_RESET  = 20'd60000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD     = 3'd0,
    FUNC_SCHED   = 3'd1,
    FUNC_REMOVE  = 3'd2,
    FUNC_FIND    = 3'd3,
    FUNC_SUMMARY = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE = 1'b0,
    CFG_MAX  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic               manual;
    logic [IDX_W-1:0]   index;
    logic [RETRY_W-1:0] retries;
    logic [TIME_W-1:0]  after_ms;
    logic               jitter_en;
    logic [JIT_W-1:0]   jitter;
    logic [TIME_W-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic               ready_found;
    logic [IDX_W-1:0]   ready_index;
    logic [KEY_W-1:0]   ready_key;
    logic               ready_manual;
    logic [RETRY_W-1:0] ready_retries;
    logic [DELAY_W-1:0] backoff_ms;
    logic [CNT_W-1:0]   ready_total;
    logic [CNT_W-1:0]   delayed_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_run;
    logic bo_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              key_zero;
    logic              idx_ok;
    logic              hit;
    logic              last;
    logic              bo_done;
  } status_t;

endpackage

FILE: hw/rtl/rqb_backoff.sv
// Iterative backoff delay unit: one doubling per cycle, then cap and jitter.
module rqb_backoff (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rqb_pkg::RETRY_W-1:0]   retries_i,
  input  logic [rqb_pkg::TIME_W-1:0]    after_i,
  input  logic                          jit_on_i,
  input  logic [rqb_pkg::JIT_W-1:0]     jitter_i,
  input  logic [rqb_pkg::DELAY_W-1:0]   base_i,
  input  logic [rqb_pkg::DELAY_W-1:0]   max_i,
  output logic                          done_o,
  output logic [rqb_pkg::DELAY_W-1:0]   delay_o
);
  import rqb_pkg::*;

  typedef enum logic {
    BO_IDLE,
    BO_RUN
  } bo_state_e;

  bo_state_e          state_q;
  logic [DELAY_W-1:0] b_q;
  logic [RETRY_W-1:0] cnt_q;
  logic [DELAY_W-1:0] delay_q;
  logic               done_q;

  logic [DELAY_W-1:0] half;
  logic               stop_thr;
  logic               stop;
  logic [DELAY_W-1:0] fin_b;
  logic [DELAY_W-1:0] cap_b;
  logic [DELAY_W:0]   sum_b;
  logic [DELAY_W-1:0] jit_b;
  logic [DELAY_W-1:0] out_b;
  logic [DELAY_W-1:0] after_cap;

  assign half     = max_i >> 1;
  assign stop_thr = (cnt_q != '0) && (b_q >= half);
  // a zero delay never grows, so the loop can end early
  assign stop     = (cnt_q == '0) || stop_thr || (b_q == '0);
  assign fin_b    = stop_thr ? max_i : b_q;
  assign cap_b    = (fin_b > max_i) ? max_i : fin_b;
  assign sum_b    = (DELAY_W+1)'(cap_b) + (DELAY_W+1)'(jitter_i);
  assign jit_b    = (sum_b <= (DELAY_W+1)'(max_i)) ? sum_b[DELAY_W-1:0] : max_i;
  assign out_b    = jit_on_i ? jit_b : cap_b;
  assign after_cap = (after_i > TIME_W'(max_i)) ? max_i : after_i[DELAY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BO_IDLE;
      b_q     <= '0;
      cnt_q   <= '0;
      delay_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        BO_IDLE: begin
          if (start_i) begin
            if (after_i != '0) begin
              delay_q <= after_cap;
              done_q  <= 1'b1;
            end else begin
              b_q     <= base_i;
              cnt_q   <= (retries_i > RETRY_W'(1)) ? retries_i - RETRY_W'(1) : '0;
              state_q <= BO_RUN;
            end
          end
        end
        BO_RUN: begin
          if (stop) begin
            delay_q <= out_b;
            done_q  <= 1'b1;
            state_q <= BO_IDLE;
          end else begin
            b_q   <= {b_q[DELAY_W-2:0], 1'b0};
            cnt_q <= cnt_q - RETRY_W'(1);
          end
        end
        default: state_q <= BO_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign delay_o = delay_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == BO_IDLE))
    else $error("backoff done raised while still iterating");

endmodule

FILE: hw/rtl/rqb_datapath.sv
// Retry table datapath: entry memories, slot scan, commit writes and result word.
module rqb_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rqb_pkg::in_t                    in_i,
  input  logic                            cfg_we_i,
  input  logic [rqb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rqb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  rqb_pkg::cmd_t                   cmd_i,
  output rqb_pkg::status_t                status_o,
  output logic                            result_valid_o,
  output rqb_pkg::out_t                   result_o
);
  import rqb_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = (IW + 1 > IDX_W) ? IW + 1 : IDX_W;
  localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

  // configuration
  logic [DELAY_W-1:0] base_q;
  logic [DELAY_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      max_q  <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE: base_q <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched command word
  in_t op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_i;
    end
  end

  // entry storage
  logic [KEY_W-1:0]   key_mem  [QUEUE_DEPTH];
  logic               man_mem  [QUEUE_DEPTH];
  logic [RETRY_W-1:0] ret_mem  [QUEUE_DEPTH];
  logic [TIME_W-1:0]  time_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q;

  // scan state
  logic [IW-1:0]      ptr_q;
  logic               issue_done_q;
  logic               rd_vld_q;
  logic               match_found_q;
  logic               free_found_q;
  logic               found_q;
  logic [CNT_W-1:0]   ready_cnt_q;
  logic [CNT_W-1:0]   delayed_cnt_q;

  logic [IW-1:0]      rd_slot_q;
  logic               vld_rd_q;
  logic [KEY_W-1:0]   key_rd_q;
  logic               man_rd_q;
  logic [RETRY_W-1:0] ret_rd_q;
  logic [TIME_W-1:0]  time_rd_q;
  logic [IW-1:0]      match_slot_q;
  logic [IW-1:0]      free_slot_q;
  logic [IW-1:0]      fnd_slot_q;
  logic [KEY_W-1:0]   fnd_key_q;
  logic               fnd_man_q;
  logic [RETRY_W-1:0] fnd_ret_q;

  logic               issue;
  logic               eval;
  logic [TIME_W-1:0]  diff;
  logic               due;
  logic               key_hit;
  logic               due_hit;
  logic               is_add;
  logic               is_find;
  logic               is_sum;
  logic               idx_ok;
  logic [IW-1:0]      idx_slot;

  // backoff unit
  logic               bo_done;
  logic [DELAY_W-1:0] bo_delay;

  rqb_backoff u_backoff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.bo_start),
    .retries_i (op_q.retries),
    .after_i   (op_q.after_ms),
    .jit_on_i  (op_q.jitter_en),
    .jitter_i  (op_q.jitter),
    .base_i    (base_q),
    .max_i     (max_q),
    .done_o    (bo_done),
    .delay_o   (bo_delay)
  );

  assign is_add   = (op_q.func == FUNC_ADD);
  assign is_find  = (op_q.func == FUNC_FIND);
  assign is_sum   = (op_q.func == FUNC_SUMMARY);
  assign idx_ok   = CW'(op_q.index) < CW'(QUEUE_DEPTH);
  assign idx_slot = IW'(op_q.index);

  assign issue   = cmd_i.scan_run & ~issue_done_q;
  assign eval    = cmd_i.scan_run & rd_vld_q;
  // due when zero, or when now - next time is not negative as a signed word
  assign diff    = op_q.now_ms - time_rd_q;
  assign due     = (time_rd_q == '0) | ~diff[TIME_W-1];
  assign key_hit = vld_rd_q & (key_rd_q == op_q.key);
  assign due_hit = vld_rd_q & due;

  assign status_o.func     = op_q.func;
  assign status_o.key_zero = (op_q.key == '0);
  assign status_o.idx_ok   = idx_ok;
  assign status_o.hit      = eval & ((is_add & key_hit) | (is_find & due_hit));
  assign status_o.last     = eval & (rd_slot_q == LAST);
  assign status_o.bo_done  = bo_done;

  // commit: writes and result word
  logic               we_key;
  logic               we_man;
  logic               we_ret;
  logic               we_time;
  logic               set_valid;
  logic               clr_valid;
  logic [IW-1:0]      waddr;
  logic               wman;
  logic [RETRY_W-1:0] wret;
  logic [TIME_W-1:0]  wtime;
  logic [TIME_W-1:0]  next_time;
  out_t               res_d;
  out_t               res_q;
  logic               res_valid_q;

  assign next_time = op_q.now_ms + TIME_W'(bo_delay);

  always_comb begin
    res_d     = '0;
    we_key    = 1'b0;
    we_man    = 1'b0;
    we_ret    = 1'b0;
    we_time   = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    waddr     = '0;
    wman      = op_q.manual;
    wret      = '0;
    wtime     = '0;
    if (cmd_i.commit) begin
      case (op_q.func)
        FUNC_ADD: begin
          if (op_q.key != '0) begin
            if (match_found_q) begin
              // bump: due now, manual flag only ever set
              waddr    = match_slot_q;
              we_time  = 1'b1;
              we_man   = op_q.manual;
              wman     = 1'b1;
              res_d.ok = 1'b1;
            end else if (free_found_q) begin
              waddr     = free_slot_q;
              we_key    = 1'b1;
              we_man    = 1'b1;
              we_ret    = 1'b1;
              we_time   = 1'b1;
              set_valid = 1'b1;
              res_d.ok  = 1'b1;
            end
          end
        end
        FUNC_SCHED: begin
          if (idx_ok) begin
            waddr            = idx_slot;
            we_ret           = 1'b1;
            we_time          = 1'b1;
            wret             = op_q.retries;
            wtime            = next_time;
            res_d.ok         = 1'b1;
            res_d.backoff_ms = bo_delay;
          end
        end
        FUNC_REMOVE: begin
          if (idx_ok) begin
            waddr     = idx_slot;
            clr_valid = 1'b1;
            res_d.ok  = 1'b1;
          end
        end
        FUNC_FIND: begin
          if (found_q) begin
            res_d.ok            = 1'b1;
            res_d.ready_found   = 1'b1;
            res_d.ready_index   = IDX_W'(fnd_slot_q);
            res_d.ready_key     = fnd_key_q;
            res_d.ready_manual  = fnd_man_q;
            res_d.ready_retries = fnd_ret_q;
          end
        end
        FUNC_SUMMARY: begin
          res_d.ok            = 1'b1;
          res_d.ready_total   = ready_cnt_q;
          res_d.delayed_total = delayed_cnt_q;
        end
        default: ;
      endcase
    end
  end

  // control side of the scan, valid bits, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      ptr_q         <= '0;
      issue_done_q  <= 1'b0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      found_q       <= 1'b0;
      ready_cnt_q   <= '0;
      delayed_cnt_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.commit;
      rd_vld_q    <= issue;
      if (set_valid) valid_q[waddr] <= 1'b1;
      if (clr_valid) valid_q[waddr] <= 1'b0;
      if (cmd_i.load) begin
        ptr_q         <= '0;
        issue_done_q  <= 1'b0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        found_q       <= 1'b0;
        ready_cnt_q   <= '0;
        delayed_cnt_q <= '0;
      end else begin
        if (issue) begin
          ptr_q <= ptr_q + IW'(1);
          if (ptr_q == LAST) issue_done_q <= 1'b1;
        end
        if (eval) begin
          if (is_add && key_hit) match_found_q <= 1'b1;
          if (is_add && !vld_rd_q) free_found_q <= 1'b1;
          if (is_find && due_hit) found_q <= 1'b1;
          if (is_sum && vld_rd_q) begin
            if (due) ready_cnt_q   <= ready_cnt_q + CNT_W'(1);
            else     delayed_cnt_q <= delayed_cnt_q + CNT_W'(1);
          end
        end
      end
    end
  end

  // memories and captured payload
  always_ff @(posedge clk_i) begin
    if (we_key)  key_mem[waddr]  <= op_q.key;
    if (we_man)  man_mem[waddr]  <= wman;
    if (we_ret)  ret_mem[waddr]  <= wret;
    if (we_time) time_mem[waddr] <= wtime;
    if (issue) begin
      rd_slot_q <= ptr_q;
      vld_rd_q  <= valid_q[ptr_q];
      key_rd_q  <= key_mem[ptr_q];
      man_rd_q  <= man_mem[ptr_q];
      ret_rd_q  <= ret_mem[ptr_q];
      time_rd_q <= time_mem[ptr_q];
    end
    if (eval) begin
      if (is_add && !vld_rd_q && !free_found_q) free_slot_q <= rd_slot_q;
      if (is_add && key_hit) match_slot_q <= rd_slot_q;
      if (is_find && due_hit && !found_q) begin
        fnd_slot_q <= rd_slot_q;
        fnd_key_q  <= key_rd_q;
        fnd_man_q  <= man_rd_q;
        fnd_ret_q  <= ret_rd_q;
      end
    end
    if (cmd_i.commit) res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_last_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.last |-> issue_done_q)
    else $error("last slot evaluated before it was read");

  a_found_still_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && is_find && found_q) |-> valid_q[fnd_slot_q])
    else $error("reported ready slot is not valid");

endmodule

FILE: hw/rtl/rqb_ctrl.sv
// Operation sequencer: decode, table scan, backoff wait and commit.
module rqb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rqb_pkg::status_t  status_i,
  output rqb_pkg::cmd_t     cmd_o
);
  import rqb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_BACKOFF,
    S_COMMIT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.func)
          FUNC_ADD: begin
            state_d = status_i.key_zero ? S_COMMIT : S_SCAN;
          end
          FUNC_SCHED: begin
            if (status_i.idx_ok) begin
              cmd_o.bo_start = 1'b1;
              state_d        = S_BACKOFF;
            end else begin
              state_d = S_COMMIT;
            end
          end
          FUNC_FIND, FUNC_SUMMARY: state_d = S_SCAN;
          default:                 state_d = S_COMMIT;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.hit || status_i.last) state_d = S_COMMIT;
      end
      S_BACKOFF: begin
        if (status_i.bo_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/retry_queue_with_backoff_top.sv
// Retry queue with exponential backoff: top level.
// From accept, each operation passes decode and commit before the registered result
// strobe; add, find_ready and summary scan in between until a hit or the last slot, one
// slot a cycle through the registered read port; schedule_retry waits for the backoff
// unit: one doubling a cycle, at most 19 before the ceiling, unless the delay is explicit.
// A new word is taken in the cycle the result strobe is up; the receiver cannot stall.
// Reset clears all valid bits at once and loads base 2000 ms, max 60000 ms.
module retry_queue_with_backoff_top #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rqb_pkg::in_t                    in_i,
  input  logic                            cfg_we_i,
  input  logic [rqb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rqb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            result_valid_o,
  output rqb_pkg::out_t                   result_o
);
  import rqb_pkg::*;

  cmd_t    cmd;
  status_t status;

  rqb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rqb_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule
